### src/fuds_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sizes for the unsigned decimal formatter.
// No dependencies; every other file in src but fuds_out_if uses it by scoped names.
package fuds_pkg;

  // Width of the input argument field and of the part that is printed
  localparam int ARG_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;

  // Double-dabble conversion: bits shifted in per cycle, steps per value
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_WIDTH     = STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Most decimal digits of a 64-bit value
  localparam int MAX_DIGITS  = 20;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_U       = 8'h75;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NUL     = 8'h00;

  typedef enum logic {
    CMD_LITERAL,
    CMD_CONVERT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             ch;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONVERT,
    BK_EMIT
  } back_state_t;

endpackage

### src/fuds_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one format byte and its argument.
// Depends on fuds_pkg for the argument width.
interface fuds_in_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     format_char;
  logic [fuds_pkg::ARG_WIDTH-1:0] argument;

  modport source (output valid, output format_char, output argument, input ready);
  modport sink (input valid, input format_char, input argument, output ready);
endinterface

### src/fuds_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one output text byte and its end-of-run flag.
// No dependencies.
interface fuds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

### src/fuds_front.sv
`timescale 1ns / 1ps
// Front end: accepts format bytes, tracks a pending '%', emits commands.
// Depends on fuds_pkg and fuds_in_if.
module fuds_front (
  input  logic                clk,
  input  logic                rst,
  fuds_in_if.sink             fmt,
  input  fuds_pkg::q_status_t q_status,
  output logic                push,
  output fuds_pkg::cmd_t      cmd
);

  logic percent_held;
  logic percent_held_next;
  logic accept;

  assign fmt.ready = !q_status.full;
  assign accept    = fmt.valid && fmt.ready;

  always_comb begin
    percent_held_next = percent_held;
    push              = 1'b0;
    cmd.kind          = fuds_pkg::CMD_LITERAL;
    cmd.ch            = fmt.format_char;
    cmd.value         = fmt.argument[fuds_pkg::VALUE_WIDTH-1:0];
    if (accept) begin
      if (fmt.format_char == fuds_pkg::CHR_NUL) begin
        percent_held_next = 1'b0;
        push              = 1'b1;
      end else if (percent_held) begin
        if (fmt.format_char != fuds_pkg::CHR_PERCENT) begin
          percent_held_next = 1'b0;
          push              = 1'b1;
          if (fmt.format_char == fuds_pkg::CHR_U) begin
            cmd.kind = fuds_pkg::CMD_CONVERT;
          end
        end
      end else if (fmt.format_char == fuds_pkg::CHR_PERCENT) begin
        percent_held_next = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_held <= 1'b0;
    end else begin
      percent_held <= percent_held_next;
    end
  end

endmodule

### src/fuds_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on fuds_pkg.
module fuds_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fuds_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output fuds_pkg::cmd_t      head,
  output fuds_pkg::q_status_t status
);

  fuds_pkg::cmd_t                   entries [fuds_pkg::QUEUE_DEPTH];
  logic [fuds_pkg::QPTR_W-1:0]      wr_ptr;
  logic [fuds_pkg::QPTR_W-1:0]      rd_ptr;
  logic [fuds_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign status.full  = (count == fuds_pkg::QCNT_W'(fuds_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  function automatic logic [fuds_pkg::QPTR_W-1:0] wrap_inc(
    input logic [fuds_pkg::QPTR_W-1:0] p
  );
    if (p == fuds_pkg::QPTR_W'(fuds_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/fuds_back.sv
`timescale 1ns / 1ps
// Back end: executes queued commands, converts values to decimal digits by
// double dabble and drives the output register. Depends on fuds_pkg, fuds_out_if.
module fuds_back (
  input  logic                clk,
  input  logic                rst,
  input  fuds_pkg::cmd_t      cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  fuds_out_if.source          text
);

  fuds_pkg::back_state_t                 state;
  fuds_pkg::back_state_t                 state_next;
  logic [fuds_pkg::PAD_WIDTH-1:0]        shreg;
  fuds_pkg::bcd_t                        bcd;
  logic [fuds_pkg::STEP_CNT_W-1:0]       step_cnt;
  logic [fuds_pkg::DIGIT_IDX_W-1:0]      idx;
  logic                                  started;
  logic                                  out_valid;
  logic [7:0]                            out_char;
  logic                                  out_last;

  logic                                  slot_free;
  logic                                  load_out;
  logic [7:0]                            load_char;
  logic                                  load_last;
  logic                                  start_conv;
  logic                                  do_step;
  logic                                  idx_dec;
  logic                                  set_started;
  logic [3:0]                            digit;

  // One step of double dabble: shift in BITS_PER_STEP bits, MSB first
  function automatic fuds_pkg::bcd_t dabble(
    input fuds_pkg::bcd_t                     d_in,
    input logic [fuds_pkg::BITS_PER_STEP-1:0] bits
  );
    fuds_pkg::bcd_t d;
    d = d_in;
    for (int s = 0; s < fuds_pkg::BITS_PER_STEP; s++) begin
      for (int k = 0; k < fuds_pkg::MAX_DIGITS; k++) begin
        if (d[k] >= 4'd5) begin
          d[k] = d[k] + 4'd3;
        end
      end
      d = fuds_pkg::bcd_t'({d, bits[fuds_pkg::BITS_PER_STEP-1-s]});
    end
    return d;
  endfunction

  assign text.valid       = out_valid;
  assign text.out_char    = out_char;
  assign text.last_of_run = out_last;
  assign slot_free        = !out_valid || text.ready;
  assign digit            = bcd[idx];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fuds_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.kind == fuds_pkg::CMD_CONVERT) begin
          state_next = fuds_pkg::BK_CONVERT;
        end
      end
      fuds_pkg::BK_CONVERT: begin
        if (step_cnt == '0) begin
          state_next = fuds_pkg::BK_EMIT;
        end
      end
      fuds_pkg::BK_EMIT: begin
        if (load_out && idx == '0) begin
          state_next = fuds_pkg::BK_IDLE;
        end
      end
      default: state_next = fuds_pkg::BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop     = 1'b0;
    load_out    = 1'b0;
    load_char   = cmd.ch;
    load_last   = 1'b1;
    start_conv  = 1'b0;
    do_step     = 1'b0;
    idx_dec     = 1'b0;
    set_started = 1'b0;
    unique case (state)
      fuds_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == fuds_pkg::CMD_CONVERT) begin
            cmd_pop    = 1'b1;
            start_conv = 1'b1;
          end else if (slot_free) begin
            cmd_pop  = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      fuds_pkg::BK_CONVERT: begin
        do_step = 1'b1;
      end
      fuds_pkg::BK_EMIT: begin
        load_char = fuds_pkg::CHR_ZERO + {4'd0, digit};
        load_last = (idx == '0);
        if (!started && digit == 4'd0 && idx != '0) begin
          idx_dec = 1'b1;
        end else if (slot_free) begin
          load_out    = 1'b1;
          set_started = 1'b1;
          idx_dec     = (idx != '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fuds_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char <= load_char;
      out_last <= load_last;
    end
    if (start_conv) begin
      shreg    <= fuds_pkg::PAD_WIDTH'(cmd.value);
      bcd      <= '0;
      step_cnt <= fuds_pkg::STEP_CNT_W'(fuds_pkg::STEPS - 1);
    end else if (do_step) begin
      bcd      <= dabble(bcd, shreg[fuds_pkg::PAD_WIDTH-1 -: fuds_pkg::BITS_PER_STEP]);
      shreg    <= shreg << fuds_pkg::BITS_PER_STEP;
      step_cnt <= step_cnt - 1'b1;
    end
    if (do_step && step_cnt == '0) begin
      idx     <= fuds_pkg::DIGIT_IDX_W'(fuds_pkg::MAX_DIGITS - 1);
      started <= 1'b0;
    end else begin
      if (idx_dec) begin
        idx <= idx - 1'b1;
      end
      if (set_started) begin
        started <= 1'b1;
      end
    end
  end

endmodule

### src/format_unsigned_decimal_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming unsigned decimal formatter.
// Depends on fuds_pkg, fuds_in_if, fuds_out_if, fuds_front, fuds_cmd_fifo, fuds_back.
//
// Channels:
//   fmt  (sink)   : one format byte per transaction plus the argument printed if
//                   the byte completes a "%u"; only its low VALUE_WIDTH bits are used.
//   text (source) : one output byte per transaction; last_of_run marks the final
//                   byte caused by one input transaction.
//   A '%' is held and produces nothing; "%u" prints the argument in decimal, most
//   significant digit first; "%%" keeps the mark held; '%' and another byte prints
//   that byte; a NUL prints 0 and clears the mark.
// Timing:
//   Ordinary bytes: the output register loads in the cycle the command leaves the
//   queue, the cycle after the input transaction when the back end is idle and its
//   output register free, so a run of literals streams at one byte per cycle while
//   text.ready stays high. "%u": a start step, STEPS double-dabble steps, then a
//   walk over all MAX_DIGITS (20) digit positions that skips leading zeros and
//   emits one digit a cycle while the output register is free. The front keeps
//   accepting until the queue fills.
// Reset: synchronous rst clears the held '%', the queue and the output valid.
// Stalls: a low text.ready holds the output register and stops the back end at its
//   next output byte; the two-entry command queue fills and fmt.ready drops.
module format_unsigned_decimal_stream (
  input  logic        clk,
  input  logic        rst,
  fuds_in_if.sink     fmt,
  fuds_out_if.source  text
);

  // Front-to-queue and queue-to-back connections
  logic                push;
  fuds_pkg::cmd_t      push_cmd;
  fuds_pkg::cmd_t      head;
  fuds_pkg::q_status_t q_status;
  logic                pop;

  fuds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .fmt      (fmt),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  fuds_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  fuds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head),
    .cmd_valid (!q_status.empty),
    .cmd_pop   (pop),
    .text      (text)
  );

  // Queue can never be full and empty at once
  a_queue_consistent: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("command queue reports full and empty together");

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("command pushed into full queue");

  // Back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("command popped from empty queue");

  // A popped command frees a slot unless a push lands in the same cycle
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> !q_status.full)
    else $error("queue still full after a pop");

endmodule

### sim/tb_format_unsigned_decimal_stream.sv
`timescale 1ns / 1ps
// Self-checking bench for format_unsigned_decimal_stream: a directed table, then random traffic.
// Depends on fuds_pkg, fuds_in_if, fuds_out_if and the formatter RTL in src.
module tb_format_unsigned_decimal_stream;

  // Run sizing
  localparam int N_DIR           = 26;
  localparam int N_RANDOM        = 336;
  localparam int STEADY_ITEMS    = 50;      // last random items run with no idling
  localparam int HOLD_OFF_CYCLES = 150;     // long receiver stall, fills the command queue
  localparam int DRAIN_CYCLES    = 60;      // more than one full conversion
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  // Only the low VALUE_WIDTH bits of an argument are printed
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - fuds_pkg::VALUE_WIDTH);

  // One output text byte as the formatter sends it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  // One row of the directed table. When typed is set, the n bytes of txt
  // (first byte leftmost) are the expected text; otherwise predict it.
  typedef struct packed {
    logic         typed;
    logic [7:0]   ch;
    logic [63:0]  arg;
    logic [4:0]   n;
    logic [159:0] txt;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [63:0] arg;
  } fmt_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fuds_in_if  fmt_ch ();
  fuds_out_if text_ch ();

  format_unsigned_decimal_stream DUT (
    .clk  (clk),
    .rst  (rst),
    .fmt  (fmt_ch),
    .text (text_ch)
  );

  always #1 clk = ~clk;

  // Directed table: extremes, every kind of byte and each corner of the '%' handling
  dir_row_t directed_rows [N_DIR] = '{
    '{1'b1, "A",                  64'd0,                  5'd1,  160'("A")},
    '{1'b1, fuds_pkg::CHR_NUL,    64'hFFFF_FFFF_FFFF_FFFF, 5'd1,  160'h0},
    '{1'b1, 8'hFF,                64'd0,                  5'd1,  160'hFF},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'hA5A5_5A5A_0F0F_F0F0, 5'd0,  160'h0},
    // zero argument prints a single '0'
    '{1'b1, fuds_pkg::CHR_U,      64'd0,                  5'd1,  160'("0")},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    // largest value: twenty digits
    '{1'b1, fuds_pkg::CHR_U, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20, 160'("18446744073709551615")},
    // "%%u": the second percent keeps the mark held
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd3,                 5'd0,  160'h0},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd4,                 5'd0,  160'h0},
    '{1'b1, fuds_pkg::CHR_U,      64'd1,                  5'd1,  160'("1")},
    // unknown conversion passes the byte through
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd9,                 5'd0,  160'h0},
    '{1'b1, "d",                  64'd5,                  5'd1,  160'("d")},
    // terminator after a held percent
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd8,                 5'd0,  160'h0},
    '{1'b1, fuds_pkg::CHR_NUL,    64'd42,                 5'd1,  160'h0},
    // 'u' with no percent held is an ordinary byte
    '{1'b1, fuds_pkg::CHR_U,      64'd7,                  5'd1,  160'("u")},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    '{1'b1, fuds_pkg::CHR_U, 64'd10000000000000000000, 5'd20, 160'("10000000000000000000")},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    '{1'b0, fuds_pkg::CHR_U,      64'd9999999999999999999, 5'd0, 160'h0},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    '{1'b1, 8'h80,                64'd0,                  5'd1,  160'h80},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    '{1'b0, fuds_pkg::CHR_U,      64'h8000_0000_0000_0000, 5'd0, 160'h0},
    '{1'b1, 8'h7F,                64'hFFFF_0000_FFFF_0000, 5'd1, 160'h7F},
    '{1'b1, fuds_pkg::CHR_PERCENT, 64'd0,                 5'd0,  160'h0},
    '{1'b0, fuds_pkg::CHR_U,      64'hFFFF_FFFF,          5'd0,  160'h0}
  };

  // Predictor state and the text still owed by the formatter, oldest first
  logic         percent_held;
  text_byte_t   text_expected[$];

  // Expectation that travels with the byte currently offered
  logic         cur_typed;
  logic [4:0]   cur_n;
  logic [159:0] cur_txt;

  // Handshakes between stimulus and receiver
  logic         hold_off_req = 1'b0;
  logic         steady_tail  = 1'b0;

  int fail_count      = 0;
  int items_accepted  = 0;
  int bytes_seen      = 0;
  int conversions     = 0;
  int longest_number  = 0;
  int cycle_count     = 0;

  // Work out the text one accepted format byte produces and advance the held mark
  function automatic void format_predict(input logic [7:0] ch, input logic [63:0] arg,
                                         ref text_byte_t res[$]);
    logic [63:0] work;
    logic [3:0]  digits [fuds_pkg::MAX_DIGITS];
    int          count;
    int          i;
    if (ch == fuds_pkg::CHR_NUL) begin
      percent_held = 1'b0;
      res.push_back('{fuds_pkg::CHR_NUL, 1'b1});
    end else if (percent_held && ch == fuds_pkg::CHR_PERCENT) begin
      // stay held, no text
    end else if (percent_held && ch == fuds_pkg::CHR_U) begin
      percent_held = 1'b0;
      work  = arg & VALUE_MASK;
      count = 0;
      do begin
        digits[count] = 4'(work % 10);
        count++;
        work = work / 10;
      end while (work != 0);
      for (i = count - 1; i >= 0; i--)
        res.push_back('{fuds_pkg::CHR_ZERO + 8'(digits[i]), i == 0});
      conversions++;
      if (count > longest_number) longest_number = count;
    end else if (percent_held) begin
      percent_held = 1'b0;
      res.push_back('{ch, 1'b1});
    end else if (ch == fuds_pkg::CHR_PERCENT) begin
      percent_held = 1'b1;
    end else begin
      res.push_back('{ch, 1'b1});
    end
  endfunction

  function automatic logic [63:0] random_arg();
    logic [63:0] v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return {64{1'b1}};
      2:       return v;
      default: return v >> $urandom_range(1, 63);
    endcase
  endfunction

  // Monitor: check text transactions first, then record the format transaction of this edge
  always @(posedge clk) begin
    text_byte_t want;
    text_byte_t got;
    text_byte_t predicted[$];
    int         k;
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) begin
        got = '{text_ch.out_char, text_ch.last_of_run};
        if (text_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected text byte %0d: char %h last %b", bytes_seen, got.ch, got.last);
        end else begin
          want = text_expected.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch at text byte %0d: expected char %h last %b, got char %h last %b",
                       bytes_seen, want.ch, want.last, got.ch, got.last);
          end
        end
        bytes_seen++;
      end
      if (fmt_ch.valid && fmt_ch.ready) begin
        predicted.delete();
        // advance the held mark even when the row types its own answer
        format_predict(fmt_ch.format_char, fmt_ch.argument, predicted);
        if (cur_typed) begin
          for (k = 0; k < cur_n; k++)
            text_expected.push_back('{cur_txt[(cur_n - 1 - k) * 8 +: 8], k == cur_n - 1});
        end else begin
          foreach (predicted[j]) text_expected.push_back(predicted[j]);
        end
        items_accepted++;
      end
    end
  end

  // Offer one format byte, after an optional idle burst, and hold it until accepted
  task automatic send_item(input logic [7:0] ch, input logic [63:0] arg, input logic typed,
                           input logic [4:0] n, input logic [159:0] txt);
    int gap;
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      fmt_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    fmt_ch.valid       <= 1'b1;
    fmt_ch.format_char <= ch;
    fmt_ch.argument    <= arg;
    cur_typed          <= typed;
    cur_n              <= n;
    cur_txt            <= txt;
    do @(posedge clk); while (!fmt_ch.ready);
  endtask

  // Receiver: random ready bursts, one long hold-off on request, steady at the end
  initial begin : text_sink
    int   held;
    int   span;
    logic level;
    text_ch.ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          @(negedge clk);
          text_ch.ready <= 1'b0;
        end
      end else begin
        if (steady_tail) begin
          level = 1'b1;
          span  = 1;
        end else if ($urandom_range(0, 2) == 0) begin
          level = 1'b0;
          span  = $urandom_range(1, 6);
        end else begin
          level = 1'b1;
          span  = $urandom_range(1, 16);
        end
        repeat (span) begin
          @(negedge clk);
          text_ch.ready <= level;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("format_unsigned_decimal_stream test failed");
    $finish;
  end

  // Stimulus: reset, directed table, random sequences, drain, verdict
  initial begin : stimulus
    fmt_item_t pending[$];
    fmt_item_t item;
    int        sent_random;
    int        pick;
    int        r;
    logic [7:0] other;
    logic      paused;

    fmt_ch.valid       = 1'b0;
    fmt_ch.format_char = 8'h00;
    fmt_ch.argument    = '0;
    cur_typed          = 1'b0;
    cur_n              = '0;
    cur_txt            = '0;
    percent_held       = 1'b0;
    paused             = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (r = 0; r < N_DIR; r++)
      send_item(directed_rows[r].ch, directed_rows[r].arg, directed_rows[r].typed,
                directed_rows[r].n, directed_rows[r].txt);

    // Stall the receiver for a long stretch while bytes keep coming
    hold_off_req = 1'b1;

    sent_random = 0;
    while (sent_random < N_RANDOM) begin
      if (pending.size() == 0) begin
        // Build one short sequence; the most common kind is a well-formed conversion
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          pending.push_back('{fuds_pkg::CHR_PERCENT, random_arg()});
          pending.push_back('{fuds_pkg::CHR_U, random_arg()});
        end else if (pick < 60) begin
          pending.push_back('{8'($urandom_range(8'h20, 8'h7E)), random_arg()});
        end else if (pick < 67) begin
          pending.push_back('{fuds_pkg::CHR_PERCENT, random_arg()});
          pending.push_back('{fuds_pkg::CHR_PERCENT, random_arg()});
          pending.push_back('{fuds_pkg::CHR_U, random_arg()});
        end else if (pick < 75) begin
          other = 8'($urandom_range(1, 255));
          if (other == fuds_pkg::CHR_U || other == fuds_pkg::CHR_PERCENT) other = "x";
          pending.push_back('{fuds_pkg::CHR_PERCENT, random_arg()});
          pending.push_back('{other, random_arg()});
        end else if (pick < 83) begin
          pending.push_back('{fuds_pkg::CHR_NUL, random_arg()});
        end else if (pick < 95) begin
          pending.push_back('{8'($urandom_range(0, 255)), {$urandom, $urandom}});
        end else begin
          pending.push_back('{fuds_pkg::CHR_PERCENT, random_arg()});
          pending.push_back('{fuds_pkg::CHR_NUL, random_arg()});
        end
      end

      // Halfway through, pause until the formatter has owed text delivered
      if (!paused && sent_random >= N_RANDOM / 2) begin
        paused = 1'b1;
        @(negedge clk);
        fmt_ch.valid <= 1'b0;
        while (text_expected.size() != 0) @(posedge clk);
      end

      if (sent_random >= N_RANDOM - STEADY_ITEMS) steady_tail = 1'b1;

      item = pending.pop_front();
      send_item(item.ch, item.arg, 1'b0, 5'd0, 160'h0);
      sent_random++;
    end

    @(negedge clk);
    fmt_ch.valid <= 1'b0;

    // Drain owed text, then give the back end time to show anything extra
    while (text_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d format bytes (%0d directed), %0d text bytes, %0d conversions",
             items_accepted, N_DIR, bytes_seen, conversions);
    $display("Longest number %0d digits, %0d cycles, %0d failures",
             longest_number, cycle_count, fail_count);
    if (fail_count == 0 && text_expected.size() == 0) begin
      $display("format_unsigned_decimal_stream test passed");
    end else begin
      $display("format_unsigned_decimal_stream test failed");
    end
    $finish;
  end

endmodule
